// ----- sv/sfdm_pkg.sv -----
// Shared types, constants and field layouts of the sensor fault debounce monitor.
package sfdm_pkg;

    localparam int CHANNELS_DEF = 8;

    // Configuration port: eight 50-bit setup words at 8-byte strides
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int SETUP_W    = 50;
    localparam int REG_SEL_LO = 3;

    // Bit-serial divider: 500 * 65535 fits in 25 bits
    localparam int          DVD_W       = 25;
    localparam int          DIV_CNT_W   = 5;
    localparam int          DIV_STEPS   = 25;
    localparam logic [8:0]  RATIO_SCALE = 9'd500;

    localparam int          RATIO_SHIFT  = 3;
    localparam int          SINGLE_SHIFT = 2;
    localparam logic [31:0] RATIO_LO     = 32'd800;
    localparam logic [31:0] RATIO_HI     = 32'd1200;

    localparam logic [15:0] SPEED_RUN  = 16'd600;
    localparam logic [31:0] HOLD_OFF_MS = 32'd5000;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_RATIO    = 2'd1;
    localparam logic [1:0] KIND_TRANSFER = 2'd2;
    localparam logic [1:0] KIND_SINGLE   = 2'd3;

    typedef struct packed {
        logic [15:0] limit;
        logic [15:0] hi;
        logic [15:0] lo;
        logic [1:0]  kind;
    } setup_t;

    typedef enum logic [1:0] {
        FS_NO_FAULT = 2'd0,
        FS_ACTIVE   = 2'd1,
        FS_CLEARED  = 2'd2
    } fault_st_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_DIVIDE,
        CS_FILTER,
        CS_COMMIT
    } ctrl_st_t;

    typedef struct packed {
        logic        running;
        logic [31:0] start_time;
    } engine_t;

endpackage

// ----- sv/sfdm_divider.sv -----
// Bit-serial restoring divider for the 500*a/b ratio, one quotient bit per cycle.
module sfdm_divider
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [15:0]               dividend_in,
    input  logic [15:0]               divisor_in,
    output logic                      done,
    output logic [sfdm_pkg::DVD_W-1:0] quotient
);

    logic [sfdm_pkg::DVD_W-1:0]     dvd_reg;
    logic [sfdm_pkg::DVD_W-1:0]     dvd_next;
    logic [15:0]                    rem_reg;
    logic [15:0]                    rem_next;
    logic [15:0]                    divisor_reg;
    logic [sfdm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [16:0]                    shifted;
    logic [16:0]                    diff;
    logic                           fits;

    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[sfdm_pkg::DVD_W-1]};
        diff     = shifted - {1'b0, divisor_reg};
        fits     = shifted >= {1'b0, divisor_reg};
        rem_next = fits ? diff[15:0] : shifted[15:0];
        // Quotient bits shift in behind the dividend bits
        dvd_next = {dvd_reg[sfdm_pkg::DVD_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == sfdm_pkg::DIV_CNT_W'(sfdm_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg     <= sfdm_pkg::DVD_W'(dividend_in)
                           * sfdm_pkg::DVD_W'(sfdm_pkg::RATIO_SCALE);
            rem_reg     <= '0;
            divisor_reg <= divisor_in;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- sv/sfdm_filter.sv -----
// IIR filter update and range or order check of one channel reading.
module sfdm_filter
(
    input  logic [1:0]                  kind,
    input  logic [15:0]                 first_value,
    input  logic [15:0]                 second_value,
    input  logic [sfdm_pkg::DVD_W-1:0]  quotient,
    input  logic [31:0]                 f_old,
    input  logic [15:0]                 lo,
    input  logic [15:0]                 hi,
    output logic [31:0]                 f_new,
    output logic                        bad
);

    logic [31:0] q32;
    logic [31:0] f8;
    logic [31:0] f4;
    logic [31:0] f_ratio;
    logic [31:0] f_single;

    always_comb
    begin
        // Saturate the quotient on a zero divisor
        q32      = (second_value == 16'd0) ? '1 : 32'(quotient);
        f8       = f_old >> sfdm_pkg::RATIO_SHIFT;
        f4       = f_old >> sfdm_pkg::SINGLE_SHIFT;
        f_ratio  = (q32 >> sfdm_pkg::RATIO_SHIFT) + ((f8 << sfdm_pkg::RATIO_SHIFT) - f8);
        f_single = (32'(first_value) >> sfdm_pkg::SINGLE_SHIFT)
                   + ((f4 << sfdm_pkg::SINGLE_SHIFT) - f4);

        case (kind)
            sfdm_pkg::KIND_RATIO:
            begin
                f_new = f_ratio;
                bad   = (f_ratio < sfdm_pkg::RATIO_LO) || (f_ratio > sfdm_pkg::RATIO_HI);
            end
            sfdm_pkg::KIND_TRANSFER:
            begin
                f_new = f_old;
                bad   = first_value < second_value;
            end
            sfdm_pkg::KIND_SINGLE:
            begin
                f_new = f_single;
                bad   = (f_single < 32'(lo)) || (f_single > 32'(hi));
            end
            default:
            begin
                f_new = f_old;
                bad   = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/sfdm_debounce.sv -----
// Engine tracking, up/down debounce counter and fault state update of one channel.
module sfdm_debounce
(
    input  logic                 bad,
    input  logic [15:0]          limit,
    input  logic [15:0]          cnt_old,
    input  sfdm_pkg::fault_st_t  st_old,
    input  logic [15:0]          engine_speed,
    input  logic [31:0]          time_ms,
    input  sfdm_pkg::engine_t    eng_old,
    output logic [15:0]          cnt_new,
    output sfdm_pkg::fault_st_t  st_new,
    output sfdm_pkg::engine_t    eng_new
);

    logic [31:0] elapsed;
    logic        count_up;

    always_comb
    begin
        eng_new = eng_old;
        if (engine_speed > sfdm_pkg::SPEED_RUN)
        begin
            eng_new.running = 1'b1;
        end
        else if (engine_speed == 16'd0)
        begin
            eng_new.running    = 1'b0;
            eng_new.start_time = time_ms;
        end

        elapsed  = time_ms - eng_new.start_time;
        count_up = bad && (elapsed > sfdm_pkg::HOLD_OFF_MS) && eng_new.running;

        cnt_new = cnt_old;
        if (count_up)
        begin
            if (cnt_old < limit)
            begin
                cnt_new = cnt_old + 16'd1;
            end
        end
        else if (cnt_old != 16'd0)
        begin
            cnt_new = cnt_old - 16'd1;
        end

        st_new = st_old;
        case (st_old)
            sfdm_pkg::FS_NO_FAULT,
            sfdm_pkg::FS_CLEARED:
            begin
                if (cnt_new == limit)
                begin
                    st_new = sfdm_pkg::FS_ACTIVE;
                end
            end
            sfdm_pkg::FS_ACTIVE:
            begin
                if (cnt_new == 16'd0)
                begin
                    st_new = sfdm_pkg::FS_CLEARED;
                end
            end
            default:
            begin
                st_new = st_old;
            end
        endcase
    end

endmodule

// ----- sv/sensor_fault_debounce_monitor_core.sv -----
// Top level of the sensor fault debounce monitor: request sequencing, channel stores, APB.
//
// Each request takes one channel through its check and debounce counter and returns one
// result. A ratio request with a nonzero divisor runs through the 25-step bit-serial
// divider first; other requests go straight to filtering. Requests are handled one at
// a time; a finished result sits in the output register while the next request is
// taken, and a request that reaches its commit step waits there until the output
// register is free. Setup words are written over APB at byte address 8*channel; the
// user must write them only while no request is in flight; the block does not check.
module sensor_fault_debounce_monitor_core
#(
    parameter int CHANNELS = sfdm_pkg::CHANNELS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [sfdm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [sfdm_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [2:0]                      channel,
    input  logic [15:0]                     first_value,
    input  logic [15:0]                     second_value,
    input  logic [15:0]                     engine_speed,
    input  logic [31:0]                     time_ms,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      fault_state,
    output logic [15:0]                     fault_count,
    output logic [31:0]                     filtered_value,
    output logic                            condition_bad
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    sfdm_pkg::setup_t   setup_reg [CHANNELS];
    logic [2:0]         cfg_sel;
    logic               cfg_ok;
    logic               cfg_write;

    // Channel stores and engine tracking
    logic [31:0]         filter_store [CHANNELS];
    logic [15:0]         count_store  [CHANNELS];
    sfdm_pkg::fault_st_t state_store  [CHANNELS];
    sfdm_pkg::engine_t   engine_reg;

    // Request held during processing
    sfdm_pkg::ctrl_st_t  ctrl_reg;
    sfdm_pkg::ctrl_st_t  ctrl_next;
    logic                req_reg;
    logic [2:0]          chan_reg;
    logic [15:0]         a_reg;
    logic [15:0]         b_reg;
    logic [15:0]         speed_reg;
    logic [31:0]         time_reg;
    logic                ch_ok_reg;
    logic                check_reg;
    logic [31:0]         f_reg;
    logic                bad_reg;

    logic                in_ch_ok;
    logic [CH_W-1:0]     in_idx;
    logic [CH_W-1:0]     idx;
    sfdm_pkg::setup_t    in_setup;
    sfdm_pkg::setup_t    cur_setup;
    logic                accept;
    logic                go_div;
    logic                div_start;
    logic                div_done;
    logic [sfdm_pkg::DVD_W-1:0] div_quot;
    logic                out_free;
    logic                commit_fire;

    logic [31:0]         f_new;
    logic                bad_new;
    logic [15:0]         cnt_new;
    sfdm_pkg::fault_st_t st_new;
    sfdm_pkg::engine_t   eng_new;

    // Output register
    logic                out_valid_reg;
    logic [1:0]          out_state_reg;
    logic [1:0]          out_state_next;
    logic [15:0]         out_count_reg;
    logic [15:0]         out_count_next;
    logic [31:0]         out_filter_reg;
    logic [31:0]         out_filter_next;
    logic                out_bad_reg;
    logic                out_bad_next;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[sfdm_pkg::APB_ADDR_W-1:sfdm_pkg::REG_SEL_LO];
    assign cfg_ok    = int'(cfg_sel) < CHANNELS;
    assign cfg_write = psel && penable && pwrite && cfg_ok;

    always_comb
    begin
        prdata = '0;
        if (cfg_ok)
        begin
            prdata = sfdm_pkg::APB_DATA_W'(setup_reg[cfg_sel[CH_W-1:0]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                setup_reg[i] <= '0;
            end
        end
        else if (cfg_write)
        begin
            setup_reg[cfg_sel[CH_W-1:0]] <= pwdata[sfdm_pkg::SETUP_W-1:0];
        end
    end

    // ---------------- Request decode ----------------
    assign in_ch_ok  = int'(channel) < CHANNELS;
    assign in_idx    = channel[CH_W-1:0];
    assign in_setup  = setup_reg[in_idx];
    assign idx       = chan_reg[CH_W-1:0];
    assign cur_setup = setup_reg[idx];
    assign accept    = in_valid && !in_stall;
    assign go_div    = !req_type && in_ch_ok && (in_setup.kind == sfdm_pkg::KIND_RATIO)
                       && (second_value != 16'd0);
    assign out_free  = !out_valid_reg || !out_stall;

    // ---------------- Sequencer ----------------
    always_comb
    begin
        ctrl_next = ctrl_reg;
        case (ctrl_reg)
            sfdm_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl_next = go_div ? sfdm_pkg::CS_DIVIDE : sfdm_pkg::CS_FILTER;
                end
            end
            sfdm_pkg::CS_DIVIDE:
            begin
                if (div_done)
                begin
                    ctrl_next = sfdm_pkg::CS_FILTER;
                end
            end
            sfdm_pkg::CS_FILTER:
            begin
                ctrl_next = sfdm_pkg::CS_COMMIT;
            end
            sfdm_pkg::CS_COMMIT:
            begin
                if (out_free)
                begin
                    ctrl_next = sfdm_pkg::CS_IDLE;
                end
            end
            default:
            begin
                ctrl_next = sfdm_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = ctrl_reg != sfdm_pkg::CS_IDLE;
        div_start   = (ctrl_reg == sfdm_pkg::CS_IDLE) && in_valid && go_div;
        commit_fire = (ctrl_reg == sfdm_pkg::CS_COMMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= sfdm_pkg::CS_IDLE;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            chan_reg  <= channel;
            a_reg     <= first_value;
            b_reg     <= second_value;
            speed_reg <= engine_speed;
            time_reg  <= time_ms;
            ch_ok_reg <= in_ch_ok;
            check_reg <= !req_type && in_ch_ok && (in_setup.kind != sfdm_pkg::KIND_NONE);
        end
        if (ctrl_reg == sfdm_pkg::CS_FILTER)
        begin
            f_reg   <= f_new;
            bad_reg <= check_reg && bad_new;
        end
    end

    // ---------------- Datapath ----------------
    sfdm_divider u_divider
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend_in (first_value),
        .divisor_in  (second_value),
        .done        (div_done),
        .quotient    (div_quot)
    );

    sfdm_filter u_filter
    (
        .kind         (cur_setup.kind),
        .first_value  (a_reg),
        .second_value (b_reg),
        .quotient     (div_quot),
        .f_old        (filter_store[idx]),
        .lo           (cur_setup.lo),
        .hi           (cur_setup.hi),
        .f_new        (f_new),
        .bad          (bad_new)
    );

    sfdm_debounce u_debounce
    (
        .bad          (bad_reg),
        .limit        (cur_setup.limit),
        .cnt_old      (count_store[idx]),
        .st_old       (state_store[idx]),
        .engine_speed (speed_reg),
        .time_ms      (time_reg),
        .eng_old      (engine_reg),
        .cnt_new      (cnt_new),
        .st_new       (st_new),
        .eng_new      (eng_new)
    );

    // ---------------- Channel stores ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                filter_store[i] <= '0;
                count_store[i]  <= '0;
                state_store[i]  <= sfdm_pkg::FS_NO_FAULT;
            end
            engine_reg <= '0;
        end
        else if (commit_fire)
        begin
            if (req_reg)
            begin
                // Reset the fault state of every channel to no fault
                for (int i = 0; i < CHANNELS; i++)
                begin
                    state_store[i] <= sfdm_pkg::FS_NO_FAULT;
                end
            end
            else if (check_reg)
            begin
                filter_store[idx] <= f_reg;
                count_store[idx]  <= cnt_new;
                state_store[idx]  <= st_new;
                engine_reg        <= eng_new;
            end
        end
    end

    // ---------------- Result ----------------
    always_comb
    begin
        out_state_next  = '0;
        out_count_next  = '0;
        out_filter_next = '0;
        out_bad_next    = 1'b0;
        if (ch_ok_reg)
        begin
            out_count_next  = count_store[idx];
            out_filter_next = filter_store[idx];
            if (req_reg)
            begin
                out_state_next = 2'(sfdm_pkg::FS_NO_FAULT);
            end
            else if (check_reg)
            begin
                out_state_next  = 2'(st_new);
                out_count_next  = cnt_new;
                out_filter_next = f_reg;
                out_bad_next    = bad_reg;
            end
            else
            begin
                out_state_next = 2'(state_store[idx]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (commit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            out_state_reg  <= out_state_next;
            out_count_reg  <= out_count_next;
            out_filter_reg <= out_filter_next;
            out_bad_reg    <= out_bad_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fault_state    = out_state_reg;
    assign fault_count    = out_count_reg;
    assign filtered_value = out_filter_reg;
    assign condition_bad  = out_bad_reg;

    // ---------------- Assertions ----------------
    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ctrl_reg == sfdm_pkg::CS_DIVIDE)
        else $error("divider finished outside the divide step");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ctrl_reg != sfdm_pkg::CS_IDLE)
        else $error("accepted request did not start processing");

    a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        commit_fire |=> out_valid_reg)
        else $error("committed request produced no result");

    a_result_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (fault_state == sfdm_pkg::FS_NO_FAULT
                           || fault_state == sfdm_pkg::FS_ACTIVE
                           || fault_state == sfdm_pkg::FS_CLEARED))
        else $error("result carries an illegal fault state");

endmodule
